// ===== src/arc_pkg.sv =====
// Package for the address resolution cache: table size, field widths,
// action codes and sequencer states. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package arc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int ACT_W   = 2;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int SLOT_W  = 4;
    localparam int ENTRY_W = IP_W + MAC_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== src/arc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module arc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/address_resolution_cache_unit.sv =====
// Top level of the address resolution cache: sequencer, valid marks and result register.
// It depends on arc_pkg and instantiates arc_ram for the address and hardware address store.
//
//   Channel  Signals                                      Direction
//   input    i_in_valid, o_in_stall, i_action,
//            i_ip_address, i_new_mac                      in
//   output   o_out_valid, i_out_stall, o_hit,
//            o_found_mac, o_slot_used                     out
//
// Adds and lookups scan the table through the single RAM read port, one entry per cycle.
// Only one word is in the block at a time; the input stalls until its result is loaded.
// Reset is synchronous and clears the valid marks and the sequencer at once.
// A stalled output holds the block in its final state until the result register frees.
`timescale 1ns / 1ps
`default_nettype none

module address_resolution_cache_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [arc_pkg::ACT_W-1:0]  i_action,
    input  wire logic [arc_pkg::IP_W-1:0]   i_ip_address,
    input  wire logic [arc_pkg::MAC_W-1:0]  i_new_mac,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic                            o_hit,
    output logic      [arc_pkg::MAC_W-1:0]  o_found_mac,
    output logic      [arc_pkg::SLOT_W-1:0] o_slot_used
);

    import arc_pkg::*;

    t_state               r_state, n_state;
    logic [ACT_W-1:0]     r_action, n_action;
    logic [IP_W-1:0]      r_ip, n_ip;
    logic [MAC_W-1:0]     r_mac, n_mac;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]     r_pick, n_pick;
    logic                 r_found, n_found;
    logic [MAC_W-1:0]     r_res_mac, n_res_mac;
    logic [ENTRIES-1:0]   r_valid, n_valid;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_hit, n_out_hit;
    logic [MAC_W-1:0]     r_out_mac, n_out_mac;
    logic [SLOT_W-1:0]    r_out_slot, n_out_slot;

    logic                 ram_we;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [IP_W-1:0]      rd_ip;
    logic [MAC_W-1:0]     rd_mac;
    logic                 cmp_hit;
    logic                 cmp_last;
    logic                 is_add;

    arc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pick),
        .i_wdata ({r_ip, r_mac}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_ip    = ram_rdata[ENTRY_W-1:MAC_W];
    assign rd_mac   = ram_rdata[MAC_W-1:0];
    assign is_add   = (r_action == ACT_ADD);
    assign cmp_last = (r_cmp_idx == IDX_W'(ENTRIES - 1));

    // An add takes a free slot or one with the same address; a lookup needs a valid match.
    always_comb begin
        if (is_add) begin
            cmp_hit = !r_valid[r_cmp_idx] || (rd_ip == r_ip);
        end else begin
            cmp_hit = r_valid[r_cmp_idx] && (rd_ip == r_ip);
        end
    end

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_found_mac = r_out_mac;
    assign o_slot_used = r_out_slot;

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_ip        = r_ip;
        n_mac       = r_mac;
        n_idx       = r_idx;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_pick      = r_pick;
        n_found     = r_found;
        n_res_mac   = r_res_mac;
        n_valid     = r_valid;
        n_out_valid = r_out_valid;
        n_out_hit   = r_out_hit;
        n_out_mac   = r_out_mac;
        n_out_slot  = r_out_slot;
        ram_we      = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    n_action  = i_action;
                    n_ip      = i_ip_address;
                    n_mac     = i_new_mac;
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    n_pick    = '0;
                    n_found   = 1'b0;
                    n_res_mac = '0;
                    case (i_action)
                        ACT_ADD, ACT_LOOKUP: begin
                            n_state = S_SCAN;
                        end
                        ACT_CLEAR: begin
                            n_valid = '0;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_idx     = r_idx + 1'b1;
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_idx;
                if (r_cmp_vld) begin
                    if (cmp_hit) begin
                        n_pick    = r_cmp_idx;
                        n_found   = 1'b1;
                        n_res_mac = is_add ? '0 : rd_mac;
                        n_state   = is_add ? S_WRITE : S_DONE;
                    end else if (cmp_last) begin
                        // A full table on add falls back to slot zero.
                        n_pick  = '0;
                        n_state = is_add ? S_WRITE : S_DONE;
                    end
                end
            end
            S_WRITE: begin
                ram_we          = 1'b1;
                n_valid[r_pick] = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = is_add || ((r_action == ACT_LOOKUP) && r_found);
                    n_out_mac   = r_res_mac;
                    n_out_slot  = SLOT_W'(r_pick);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_vld   <= n_cmp_vld;
            r_found     <= n_found;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_ip       <= n_ip;
        r_mac      <= n_mac;
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_pick     <= n_pick;
        r_res_mac  <= n_res_mac;
        r_out_hit  <= n_out_hit;
        r_out_mac  <= n_out_mac;
        r_out_slot <= n_out_slot;
    end

endmodule

`default_nettype wire

// ===== src/arc_checker.sv =====
// Port-level checks for the address resolution cache, bound to the top level.
// It depends on arc_pkg and on address_resolution_cache_unit.
`timescale 1ns / 1ps
`default_nettype none

module arc_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic                       o_hit,
    input wire logic [arc_pkg::MAC_W-1:0]  o_found_mac,
    input wire logic [arc_pkg::SLOT_W-1:0] o_slot_used
);

    import arc_pkg::*;

    // Once a word is taken, the block is busy with it in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a word was accepted");

    // A new result only appears while a word is being worked on.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no word in progress");

    // A miss, a clear or an unused action reports no hardware address and slot zero.
    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> ((o_found_mac == '0) && (o_slot_used == '0)))
        else $error("result without a hit carries non-zero fields");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output word withdrawn while stalled");

endmodule

bind address_resolution_cache_unit arc_checker u_arc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_hit       (o_hit),
    .o_found_mac (o_found_mac),
    .o_slot_used (o_slot_used)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for address_resolution_cache_unit: directed and random add, lookup
// and clear words, each result checked against a table kept inside the bench.
// Depends on arc_pkg and the cache RTL; it reads and writes no files.

module tb_top;
    import arc_pkg::*;

    localparam int GAP_MAX      = 14;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_WAIT   = 2 * ENTRIES + 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_WORDS = 2000;
    localparam int POOL_SIZE    = 24;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic              hit;
        logic [MAC_W-1:0]  mac;
        logic [SLOT_W-1:0] slot;
    } t_cache_answer;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [ACT_W-1:0]  i_action;
    logic [IP_W-1:0]   i_ip_address;
    logic [MAC_W-1:0]  i_new_mac;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_hit;
    logic [MAC_W-1:0]  o_found_mac;
    logic [SLOT_W-1:0] o_slot_used;

    t_cache_answer     answers_due[$];
    logic              tbl_valid [ENTRIES];
    logic [IP_W-1:0]   tbl_ip [ENTRIES];
    logic [MAC_W-1:0]  tbl_mac [ENTRIES];

    int   errors       = 0;
    bit   tx_steady    = 1'b0;
    logic rx_steady    = 1'b0;
    logic hold_request = 1'b0;

    address_resolution_cache_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_ip_address (i_ip_address),
        .i_new_mac    (i_new_mac),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hit        (o_hit),
        .o_found_mac  (o_found_mac),
        .o_slot_used  (o_slot_used)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[MAC_W-1:0];
    endfunction

    function automatic t_cache_answer table_answer(logic [ACT_W-1:0] act,
                                                   logic [IP_W-1:0] ip,
                                                   logic [MAC_W-1:0] mac);
        t_cache_answer ans;
        int            pick;
        bit            found;
        ans   = '0;
        pick  = 0;
        found = 1'b0;
        if (act == ACT_ADD) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (!found && (!tbl_valid[i] || tbl_ip[i] == ip)) begin
                    found = 1'b1;
                    pick  = i;
                end
            end
            tbl_valid[pick] = 1'b1;
            tbl_ip[pick]    = ip;
            tbl_mac[pick]   = mac;
            ans.hit  = 1'b1;
            ans.slot = pick[SLOT_W-1:0];
        end else if (act == ACT_LOOKUP) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (!found && tbl_valid[i] && tbl_ip[i] == ip) begin
                    found = 1'b1;
                    pick  = i;
                end
            end
            if (found) begin
                ans.hit  = 1'b1;
                ans.mac  = tbl_mac[pick];
                ans.slot = pick[SLOT_W-1:0];
            end
        end else if (act == ACT_CLEAR) begin
            for (int i = 0; i < ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
            end
        end
        return ans;
    endfunction

    task automatic send_word(logic [ACT_W-1:0] act, logic [IP_W-1:0] ip,
                             logic [MAC_W-1:0] mac);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_ip_address <= ip;
        i_new_mac    <= mac;
        do @(posedge i_clk); while (o_in_stall);
        answers_due.push_back(table_answer(act, ip, mac));
    endtask

    task automatic report_mismatch(string field, logic [MAC_W-1:0] want,
                                   logic [MAC_W-1:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    task automatic test_empty_table();
        send_word(ACT_LOOKUP, '0, '1);
        send_word(ACT_LOOKUP, '1, '0);
        send_word(ACT_CLEAR, 32'h0A00_0001, random_mac());
        send_word(ACT_UNUSED, '1, '1);
    endtask

    task automatic test_full_table();
        logic [IP_W-1:0] held_ip [ENTRIES];
        for (int i = 0; i < ENTRIES; i++) begin
            held_ip[i] = (i == 0) ? '0 : (i == ENTRIES - 1) ? '1 : 32'hC0A8_0000 + i;
            send_word(ACT_ADD, held_ip[i],
                      (i == 0) ? '1 : (i == ENTRIES - 1) ? '0 : random_mac());
        end
        send_word(ACT_LOOKUP, held_ip[ENTRIES-1], random_mac());
        send_word(ACT_ADD, 32'hC0A8_01FF, random_mac());
        send_word(ACT_LOOKUP, held_ip[0], random_mac());
        send_word(ACT_ADD, held_ip[5], random_mac());
        send_word(ACT_LOOKUP, held_ip[5], '0);
        send_word(ACT_UNUSED, held_ip[5], random_mac());
        send_word(ACT_CLEAR, '0, '0);
        send_word(ACT_LOOKUP, held_ip[5], '1);
    endtask

    // The receiver holds off for a long stretch while words keep coming, so the
    // block fills and stalls its input.
    task automatic test_output_hold();
        logic [IP_W-1:0] base;
        base = $urandom;
        hold_request <= 1'b1;
        tx_steady = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_word((i % 2 == 0) ? ACT_ADD : ACT_LOOKUP, base + (i / 2), random_mac());
        end
        tx_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [IP_W-1:0]  pool [POOL_SIZE];
        logic [ACT_W-1:0] act;
        logic [IP_W-1:0]  ip;
        int               roll;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool[i] = $urandom;
        end
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 128 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady <= ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                act = ACT_ADD;
            end else if (roll < 97) begin
                act = ACT_LOOKUP;
            end else if (roll < 99) begin
                act = ACT_CLEAR;
            end else begin
                act = ACT_UNUSED;
            end
            ip = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, POOL_SIZE - 1)];
            send_word(act, ip, random_mac());
        end
        tx_steady = 1'b0;
    endtask

    initial begin : result_receiver
        int stall_left;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request <= 1'b0;
                stall_left = LONG_HOLD;
            end else if (o_out_valid && !i_out_stall) begin
                stall_left = rx_steady ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                if (o_out_valid) begin
                    stall_left--;
                end
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : result_checker
        t_cache_answer want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual hit %b mac %h slot %h",
                             $time, o_hit, o_found_mac, o_slot_used);
                end else begin
                    want = answers_due.pop_front();
                    if (o_hit !== want.hit) begin
                        report_mismatch("hit", MAC_W'(want.hit), MAC_W'(o_hit));
                    end
                    if (o_found_mac !== want.mac) begin
                        report_mismatch("found_mac", want.mac, o_found_mac);
                    end
                    if (o_slot_used !== want.slot) begin
                        report_mismatch("slot_used", MAC_W'(want.slot), MAC_W'(o_slot_used));
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_action     <= ACT_ADD;
        i_ip_address <= '0;
        i_new_mac    <= '0;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_ip[i]    = '0;
            tbl_mac[i]   = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_full_table();
        test_output_hold();
        test_random_traffic();

        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/arc_pkg.sv
src/arc_ram.sv
src/address_resolution_cache_unit.sv
src/arc_checker.sv
dv/tb_top.sv
